// ===== hw/rtl/rgbe_pkg.sv =====
package rgbe_pkg;

  localparam int unsigned MIN_RLE_WIDTH = 8;
  localparam int unsigned MAX_RLE_WIDTH = 32767;

  localparam logic [7:0] PLANAR_MARK = 8'd2;
  localparam logic [7:0] REPEAT_MARK = 8'd1;
  localparam logic [7:0] RUN_FLAG    = 8'd128;

  typedef enum logic [2:0] {
    MODE_DETECT = 3'b001,
    MODE_PLANAR = 3'b010,
    MODE_OLD    = 3'b100
  } mode_e;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'b001,
    KIND_RUN     = 3'b010,
    KIND_LITERAL = 3'b100
  } kind_e;

  typedef enum logic [2:0] {
    LANE_BLUE  = 3'd0,
    LANE_GREEN = 3'd1,
    LANE_RED   = 3'd2,
    LANE_EXP   = 3'd3,
    LANE_PIXEL = 3'd4
  } lane_e;

  typedef struct packed {
    logic [15:0] run_start;
    logic [15:0] run_length;
    lane_e       lane;
    logic [31:0] run_value;
    logic        line_done;
    logic        overrun;
  } run_t;

  function automatic lane_e lane_of_channel(input logic [1:0] ch);
    lane_e l;
    unique case (ch)
      2'd0:    l = LANE_RED;
      2'd1:    l = LANE_GREEN;
      2'd2:    l = LANE_BLUE;
      default: l = LANE_EXP;
    endcase
    return l;
  endfunction

endpackage

// ===== hw/rtl/rgbe_in_reg.sv =====
module rgbe_in_reg import rgbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

endmodule

// ===== hw/rtl/rgbe_decode.sv =====
module rgbe_decode import rgbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        width_we_i,
  input  logic [15:0] width_i,
  input  logic        fire_i,
  input  logic [7:0]  byte_i,
  output logic        emit_o,
  output run_t        run_o
);

  logic [15:0] width_q, width_d;
  mode_e       mode_q, mode_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  chan_q, chan_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  count_q, count_d;
  kind_e       kind_q, kind_d;
  logic [1:0]  shift_q, shift_d;
  logic [23:0] gather_q, gather_d;
  logic [31:0] prev_q, prev_d;
  logic        clamp_q, clamp_d;

  logic [15:0] w;
  logic [15:0] remain;
  logic        width_ok;
  logic [7:0]  r, g, bl;
  logic [31:0] count;
  logic [31:0] value;
  logic [15:0] len;
  logic        over;
  logic [16:0] sum;
  logic [7:0]  cnt_dec;
  logic        restart;
  logic        advance;

  assign w        = (width_q == '0) ? 16'd1 : width_q;
  assign remain   = w - pos_q;
  assign width_ok = (w >= 16'(MIN_RLE_WIDTH)) && (w <= 16'(MAX_RLE_WIDTH));
  assign r        = gather_q[7:0];
  assign g        = gather_q[15:8];
  assign bl       = gather_q[23:16];
  assign count    = {24'b0, byte_i} << {shift_q, 3'b000};
  assign cnt_dec  = count_q - 8'd1;

  always_comb begin
    width_d  = width_q;
    mode_d   = mode_q;
    phase_d  = phase_q;
    chan_d   = chan_q;
    pos_d    = pos_q;
    count_d  = count_q;
    kind_d   = kind_q;
    shift_d  = shift_q;
    gather_d = gather_q;
    prev_d   = prev_q;
    clamp_d  = clamp_q;
    emit_o   = 1'b0;
    run_o    = '0;
    value    = '0;
    len      = 16'd1;
    over     = 1'b0;
    sum      = '0;
    restart  = 1'b0;
    advance  = 1'b0;

    if (fire_i) begin
      unique case (mode_q)
        MODE_DETECT, MODE_OLD: begin
          if (phase_q != 2'd3) begin
            gather_d[{phase_q, 3'b000} +: 8] = byte_i;
            phase_d = phase_q + 2'd1;
          end else begin
            phase_d  = 2'd0;
            gather_d = '0;
            if (mode_q == MODE_DETECT && width_ok && r == PLANAR_MARK &&
                g == PLANAR_MARK && !bl[7]) begin
              mode_d = MODE_PLANAR;
              chan_d = 2'd0;
              kind_d = KIND_HEADER;
            end else begin
              mode_d = MODE_OLD;
              if (r == REPEAT_MARK && g == REPEAT_MARK && bl == REPEAT_MARK) begin
                shift_d = (shift_q == 2'd3) ? 2'd3 : shift_q + 2'd1;
                value   = prev_q;
                if (byte_i != '0) begin
                  emit_o = 1'b1;
                  if (count > {16'b0, remain}) begin
                    len  = remain;
                    over = 1'b1;
                  end else begin
                    len = count[15:0];
                  end
                end
              end else begin
                value   = {byte_i, r, g, bl};
                prev_d  = value;
                shift_d = 2'd0;
                emit_o  = 1'b1;
              end
              if (emit_o) begin
                sum   = {1'b0, pos_q} + {1'b0, len};
                pos_d = sum[15:0];
                run_o.run_start  = pos_q;
                run_o.run_length = len;
                run_o.lane       = LANE_PIXEL;
                run_o.run_value  = value;
                run_o.line_done  = sum >= {1'b0, w};
                run_o.overrun    = over;
                restart          = sum >= {1'b0, w};
              end
            end
          end
        end
        MODE_PLANAR: begin
          unique case (kind_q)
            KIND_HEADER: begin
              if (byte_i > RUN_FLAG) begin
                count_d = {1'b0, byte_i[6:0]};
                kind_d  = KIND_RUN;
              end else if (byte_i != '0) begin
                if ({8'b0, byte_i} > remain) begin
                  count_d = remain[7:0];
                  clamp_d = 1'b1;
                end else begin
                  count_d = byte_i;
                  clamp_d = 1'b0;
                end
                kind_d = KIND_LITERAL;
              end
            end
            KIND_RUN: begin
              if ({8'b0, count_q} > remain) begin
                len  = remain;
                over = 1'b1;
              end else begin
                len = {8'b0, count_q};
              end
              kind_d  = KIND_HEADER;
              count_d = '0;
              advance = 1'b1;
            end
            default: begin
              count_d = cnt_dec;
              over    = clamp_q && cnt_dec == '0;
              if (cnt_dec == '0) begin
                kind_d  = KIND_HEADER;
                clamp_d = 1'b0;
              end
              advance = 1'b1;
            end
          endcase
          if (advance) begin
            emit_o = 1'b1;
            sum    = {1'b0, pos_q} + {1'b0, len};
            run_o.run_start  = pos_q;
            run_o.run_length = len;
            run_o.lane       = lane_of_channel(chan_q);
            run_o.run_value  = {24'b0, byte_i};
            run_o.overrun    = over;
            if (sum >= {1'b0, w}) begin
              pos_d   = '0;
              kind_d  = KIND_HEADER;
              count_d = '0;
              if (chan_q == 2'd3) begin
                run_o.line_done = 1'b1;
                restart         = 1'b1;
              end else begin
                chan_d = chan_q + 2'd1;
              end
            end else begin
              pos_d = sum[15:0];
            end
          end
        end
        default: begin
          mode_d = MODE_DETECT;
        end
      endcase
    end

    if (width_we_i) begin
      width_d = width_i;
      restart = 1'b1;
    end

    if (restart) begin
      mode_d   = MODE_DETECT;
      phase_d  = '0;
      chan_d   = '0;
      pos_d    = '0;
      count_d  = '0;
      kind_d   = KIND_HEADER;
      shift_d  = '0;
      gather_d = '0;
      prev_d   = '0;
      clamp_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1;
      mode_q   <= MODE_DETECT;
      phase_q  <= '0;
      chan_q   <= '0;
      pos_q    <= '0;
      count_q  <= '0;
      kind_q   <= KIND_HEADER;
      shift_q  <= '0;
      gather_q <= '0;
      prev_q   <= '0;
      clamp_q  <= 1'b0;
    end else begin
      width_q  <= width_d;
      mode_q   <= mode_d;
      phase_q  <= phase_d;
      chan_q   <= chan_d;
      pos_q    <= pos_d;
      count_q  <= count_d;
      kind_q   <= kind_d;
      shift_q  <= shift_d;
      gather_q <= gather_d;
      prev_q   <= prev_d;
      clamp_q  <= clamp_d;
    end
  end

endmodule

// ===== hw/rtl/rgbe_out_reg.sv =====
module rgbe_out_reg import rgbe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_valid_i,
  input  run_t load_run_i,
  output logic open_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output run_t run_o
);

  logic valid_q;
  run_t run_q;

  assign open_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign run_o       = run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (open_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (open_o && load_valid_i) begin
      run_q <= load_run_i;
    end
  end

endmodule

// ===== hw/rtl/rgbe_scanline_rle_decoder.sv =====
// A byte held in the input register is decoded combinationally when it is taken, and any
// run it yields is loaded into the output register and offered on the output from there.
// Throughput: one byte per cycle while the output register is open; the output register
// drains at one per cycle. The input and output registers decouple the two channels;
// in_ready_o is high while the input register is empty or the output register is open.
// Reset: asynchronous, active low; line_width returns to 1, decode restarts at a
// line header, both registers empty.
module rgbe_scanline_rle_decoder import rgbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        line_width_we_i,
  input  logic [15:0] line_width_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] run_start_o,
  output logic [15:0] run_length_o,
  output logic [2:0]  lane_o,
  output logic [31:0] run_value_o,
  output logic        line_done_o,
  output logic        overrun_o
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       out_open;
  logic       fire;
  logic       emit;
  run_t       emit_run;
  run_t       out_run;

  assign fire = stage_valid && out_open;

  rgbe_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .take_i      (out_open),
    .valid_o     (stage_valid),
    .byte_o      (stage_byte)
  );

  rgbe_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_we_i (line_width_we_i),
    .width_i    (line_width_i),
    .fire_i     (fire),
    .byte_i     (stage_byte),
    .emit_o     (emit),
    .run_o      (emit_run)
  );

  rgbe_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (fire && emit),
    .load_run_i   (emit_run),
    .open_o       (out_open),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .run_o        (out_run)
  );

  assign run_start_o  = out_run.run_start;
  assign run_length_o = out_run.run_length;
  assign lane_o       = out_run.lane;
  assign run_value_o  = out_run.run_value;
  assign line_done_o  = out_run.line_done;
  assign overrun_o    = out_run.overrun;

endmodule
